// ===== hw/rtl/tbtap_pkg.sv =====
package tbtap_pkg;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [7:0]  ALARM_BASE    = 8'd24;
	localparam logic [7:0]  ALARM_LAST    = 8'd26;
	localparam logic [7:0]  HOUR_MAX      = 8'd23;
	localparam logic [7:0]  MINSEC_MAX    = 8'd59;
	localparam logic [7:0]  ART_HOUR      = 8'd13;
	localparam logic [7:0]  ART_MINUTE    = 8'd10;

	typedef enum logic [2:0] {
		KIND_PARTIAL  = 3'd0,
		KIND_TIME     = 3'd1,
		KIND_ALARM    = 3'd2,
		KIND_INVALID  = 3'd3,
		KIND_FILTERED = 3'd4
	} frame_kind_t;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2,
		POS_UNUSED = 2'd3
	} frame_pos_t;

	typedef struct packed {
		logic        done;
		frame_kind_t kind;
		logic        dropped;
		logic [1:0]  slot;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} result_t;

endpackage

// ===== hw/rtl/tbtap_in_reg.sv =====
module tbtap_in_reg
	import tbtap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] arrival_tick,
	input  logic        advance,
	output logic        valid_s1,
	output logic [7:0]  byte_s1,
	output logic [31:0] tick_s1
);

	logic accept;

	// take a new beat when empty or when the held beat moves on this cycle
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			tick_s1 <= arrival_tick;
		end
	end

endmodule

// ===== hw/rtl/tbtap_core.sv =====
module tbtap_core
	import tbtap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        advance,
	input  logic [7:0]  byte_s1,
	input  logic [31:0] tick_s1,
	output result_t     res
);

	logic [15:0] timeout_q;
	frame_pos_t  pos_q;
	logic [7:0]  first_q;
	logic [7:0]  second_q;
	logic [31:0] last_tick_q;

	logic [31:0] gap;
	logic        drop;
	frame_pos_t  pos_eff;
	frame_pos_t  pos_nxt;

	assign gap  = tick_s1 - last_tick_q;
	assign drop = (gap > {16'd0, timeout_q}) && (pos_q != POS_FIRST);

	always_comb begin
		pos_eff = drop ? POS_FIRST : pos_q;
		pos_nxt = POS_FIRST;
		res     = '0;
		res.kind    = KIND_PARTIAL;
		res.dropped = drop;
		case (pos_eff)
			POS_FIRST: begin
				pos_nxt = POS_SECOND;
			end
			POS_SECOND: begin
				pos_nxt = POS_THIRD;
			end
			POS_THIRD: begin
				pos_nxt  = POS_FIRST;
				res.done = 1'b1;
				if (first_q >= ALARM_BASE) begin
					if (first_q inside {[ALARM_BASE:ALARM_LAST]} && second_q <= HOUR_MAX
							&& byte_s1 <= MINSEC_MAX) begin
						res.kind   = KIND_ALARM;
						res.slot   = 2'(first_q - ALARM_BASE);
						res.hour   = second_q[4:0];
						res.minute = byte_s1[5:0];
					end else begin
						res.kind = KIND_INVALID;
					end
				end else if (second_q <= MINSEC_MAX && byte_s1 <= MINSEC_MAX) begin
					if (first_q == ART_HOUR && second_q == ART_MINUTE) begin
						res.kind = KIND_FILTERED;
					end else begin
						res.kind   = KIND_TIME;
						res.hour   = first_q[4:0];
						res.minute = second_q[5:0];
						res.second = byte_s1[5:0];
					end
				end else begin
					res.kind = KIND_INVALID;
				end
			end
			default: begin
				// unreachable position: drop the byte and restart
				pos_nxt = POS_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_FIRST;
			first_q     <= 8'd0;
			second_q    <= 8'd0;
			last_tick_q <= 32'd0;
		end else if (advance) begin
			pos_q       <= pos_nxt;
			last_tick_q <= tick_s1;
			if (pos_eff == POS_FIRST) begin
				first_q <= byte_s1;
			end
			if (pos_eff == POS_SECOND) begin
				second_q <= byte_s1;
			end
		end
	end

endmodule

// ===== hw/rtl/three_byte_time_alarm_frame_parser.sv =====
// A beat passes through the input register, then the result register, before its status
// beat shows on the outputs.
// Throughput: one byte per cycle while out_ready is high; frame position and held bytes
// update as each byte moves between the registers; a beat only waits on the one before it.
// Reset (arst_n low, asynchronous): both registers empty, frame position 0, held bytes and
// last tick 0, timeout register 500.
module three_byte_time_alarm_frame_parser
	import tbtap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: timeout in ticks; write only while the block is idle (not enforced here)
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// byte input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] arrival_tick,
	// status output channel, one beat per input byte
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_done,
	output logic [2:0]  frame_kind,
	output logic        partial_dropped,
	output logic [1:0]  alarm_slot,
	output logic [4:0]  hour_value,
	output logic [5:0]  minute_value,
	output logic [5:0]  second_value
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [31:0] tick_s1;
	logic        advance;
	result_t     res;
	result_t     res_s2;

	// Move the held byte into the result register when the result slot is free or
	// is being drained this same cycle. The frame state advances with it, so the
	// timeout check and the frame decode both see the byte exactly once.
	assign advance = valid_s1 && (!out_valid || out_ready);

	tbtap_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.arrival_tick(arrival_tick),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.tick_s1     (tick_s1)
	);

	// Frame state, timeout register and decode of the completed frame.
	tbtap_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.advance    (advance),
		.byte_s1    (byte_s1),
		.tick_s1    (tick_s1),
		.res        (res)
	);

	// Result register: hold the status beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign frame_done      = res_s2.done;
	assign frame_kind      = res_s2.kind;
	assign partial_dropped = res_s2.dropped;
	assign alarm_slot      = res_s2.slot;
	assign hour_value      = res_s2.hour;
	assign minute_value    = res_s2.minute;
	assign second_value    = res_s2.second;

	// A completed frame never reports the partial kind, and a partial never reports done.
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_done == (frame_kind != KIND_PARTIAL)))
		else $error("frame_done disagrees with frame_kind");

	// A drop restarts the frame with this byte, so it cannot also complete one.
	a_drop_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && partial_dropped) |-> !frame_done)
		else $error("dropped partial frame reported as complete");

	// Seconds only travel with an accepted time sync.
	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_kind != KIND_TIME) |-> (second_value == 6'd0))
		else $error("second_value set outside a time sync");

	// Alarm slot is zero unless an alarm was accepted.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_kind != KIND_ALARM) |-> (alarm_slot == 2'd0))
		else $error("alarm_slot set outside an alarm frame");

endmodule
